>>> hw/rtl/ber_tlv_stream_parser_defines.svh
// ============================================================================
// BER TLV stream parser - assertion macros
// Shared concurrent assertion forms for the parser RTL.
// ============================================================================
`ifndef BER_TLV_STREAM_PARSER_DEFINES_SVH
`define BER_TLV_STREAM_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BTLV_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BTLV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/btlv_pkg.sv
// ============================================================================
// BER TLV stream parser - package
// Phase encoding, result codes and the result bundle shared by the RTL.
// ============================================================================
`default_nettype none

package btlv_pkg;

   localparam int LEN_BYTES_MAX_DEF = 8;
   localparam int OFFSET_BITS_DEF   = 16;

   typedef enum logic [2:0] {
      PH_HALT  = 3'd0,
      PH_TAG   = 3'd1,
      PH_DESC  = 3'd2,
      PH_LENB  = 3'd3,
      PH_VALUE = 3'd4
   } phase_type;

   localparam logic [1:0] CLASS_TAG     = 2'd0;
   localparam logic [1:0] CLASS_LENGTH  = 2'd1;
   localparam logic [1:0] CLASS_VALUE   = 2'd2;
   localparam logic [1:0] CLASS_IGNORED = 2'd3;

   localparam logic [2:0] ERR_NONE          = 3'd0;
   localparam logic [2:0] ERR_SHORT_AT_TAG  = 3'd1;
   localparam logic [2:0] ERR_BAD_LEN_OF_LEN = 3'd2;
   localparam logic [2:0] ERR_LEN_OVERRUN   = 3'd3;
   localparam logic [2:0] ERR_VALUE_OVERRUN = 3'd4;

   typedef struct packed {
      logic [1:0]  byte_class;
      logic [7:0]  tlv_tag;
      logic [15:0] value_length;
      logic [15:0] value_offset;
      logic        header_done;
      logic        tlv_done;
      logic [2:0]  error_code;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/btlv_core.sv
// ============================================================================
// BER TLV stream parser - parse core
// Parse state registers and the per-byte classification and bound checks.
// ============================================================================
`default_nettype none

`include "ber_tlv_stream_parser_defines.svh"

module btlv_core #(
   parameter int LEN_BYTES_MAX = btlv_pkg::LEN_BYTES_MAX_DEF,
   parameter int OFFSET_BITS   = btlv_pkg::OFFSET_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        data_byte,
   input  wire logic              buffer_start,
   input  wire logic [15:0]       buffer_length,
   output btlv_pkg::rsp_type      rsp
);

   localparam int LBL_W = $clog2(LEN_BYTES_MAX + 1);
   localparam int SUM_W = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;

   btlv_pkg::phase_type      phase_ff, phase_in;
   logic [OFFSET_BITS-1:0]   offset_ff, offset_in;
   logic [15:0]              buf_len_ff, buf_len_in;
   logic [7:0]               tag_ff, tag_in;
   logic [LBL_W-1:0]         len_left_ff, len_left_in;
   logic [15:0]              acc_ff, acc_in;
   logic                     ovf_ff, ovf_in;
   logic [15:0]              val_left_ff, val_left_in;

   btlv_pkg::phase_type      eff_phase;
   logic [OFFSET_BITS-1:0]   eff_offset;
   logic [15:0]              eff_len;
   logic [6:0]               desc_n;
   logic                     desc_long;
   logic [15:0]              lenb_acc;
   logic                     lenb_ovf;
   logic [15:0]              hdr_len;
   logic                     hdr_ovf;
   logic [SUM_W-1:0]         voff;
   logic [SUM_W-1:0]         hdr_end;
   logic                     hdr_bad;
   logic                     tag_short;
   logic                     desc_bad_lol;
   logic                     desc_overrun;
   logic                     lenb_last;
   logic                     val_last;

   // A buffer start overrides whatever phase the previous buffer left.
   assign eff_phase  = buffer_start ? btlv_pkg::PH_TAG : phase_ff;
   assign eff_offset = buffer_start ? '0 : offset_ff;
   assign eff_len    = buffer_start ? buffer_length : buf_len_ff;

   assign desc_n    = data_byte[6:0];
   assign desc_long = data_byte[7];

   // Once the accumulated length has passed 16 bits it stays overflowed.
   assign lenb_acc = {acc_ff[7:0], data_byte};
   assign lenb_ovf = ovf_ff | (|acc_ff[15:8]);

   assign hdr_len = (eff_phase == btlv_pkg::PH_DESC) ? {8'd0, data_byte} : lenb_acc;
   assign hdr_ovf = (eff_phase == btlv_pkg::PH_DESC) ? 1'b0 : lenb_ovf;

   assign voff    = SUM_W'(eff_offset) + SUM_W'(1);
   assign hdr_end = voff + SUM_W'(hdr_len);
   assign hdr_bad = hdr_ovf || (hdr_end > SUM_W'(eff_len));

   assign tag_short    = (SUM_W'(eff_offset) + SUM_W'(2)) > SUM_W'(eff_len);
   assign desc_bad_lol = (desc_n == 7'd0) || (desc_n > 7'(LEN_BYTES_MAX));
   assign desc_overrun = (voff + SUM_W'(desc_n)) > SUM_W'(eff_len);
   assign lenb_last    = (len_left_ff == LBL_W'(1));
   assign val_last     = (val_left_ff == 16'd1);

   // Next state
   always_comb begin
      phase_in    = eff_phase;
      buf_len_in  = eff_len;
      tag_in      = tag_ff;
      len_left_in = len_left_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      val_left_in = val_left_ff;
      offset_in   = (eff_phase == btlv_pkg::PH_HALT) ? eff_offset
                                                     : eff_offset + OFFSET_BITS'(1);
      case (eff_phase)
         btlv_pkg::PH_TAG: begin
            tag_in   = data_byte;
            phase_in = tag_short ? btlv_pkg::PH_HALT : btlv_pkg::PH_DESC;
         end
         btlv_pkg::PH_DESC: begin
            ovf_in = 1'b0;
            if (!desc_long) begin
               acc_in = {8'd0, data_byte};
               if (hdr_bad) begin
                  phase_in = btlv_pkg::PH_HALT;
               end else if (hdr_len == 16'd0) begin
                  phase_in = btlv_pkg::PH_TAG;
               end else begin
                  val_left_in = hdr_len;
                  phase_in    = btlv_pkg::PH_VALUE;
               end
            end else begin
               acc_in = 16'd0;
               if (desc_bad_lol || desc_overrun) begin
                  phase_in = btlv_pkg::PH_HALT;
               end else begin
                  len_left_in = desc_n[LBL_W-1:0];
                  phase_in    = btlv_pkg::PH_LENB;
               end
            end
         end
         btlv_pkg::PH_LENB: begin
            acc_in      = lenb_acc;
            ovf_in      = lenb_ovf;
            len_left_in = len_left_ff - LBL_W'(1);
            if (lenb_last) begin
               if (hdr_bad) begin
                  phase_in = btlv_pkg::PH_HALT;
               end else if (hdr_len == 16'd0) begin
                  phase_in = btlv_pkg::PH_TAG;
               end else begin
                  val_left_in = hdr_len;
                  phase_in    = btlv_pkg::PH_VALUE;
               end
            end
         end
         btlv_pkg::PH_VALUE: begin
            val_left_in = val_left_ff - 16'd1;
            if (val_last) begin
               phase_in = btlv_pkg::PH_TAG;
            end
         end
         default: begin
            phase_in = btlv_pkg::PH_HALT;
         end
      endcase
   end

   // Result for the current byte
   always_comb begin
      rsp            = '0;
      rsp.byte_class = btlv_pkg::CLASS_IGNORED;
      case (eff_phase)
         btlv_pkg::PH_TAG: begin
            rsp.byte_class = btlv_pkg::CLASS_TAG;
            rsp.tlv_tag    = data_byte;
            if (tag_short) begin
               rsp.error_code = btlv_pkg::ERR_SHORT_AT_TAG;
            end
         end
         btlv_pkg::PH_DESC, btlv_pkg::PH_LENB: begin
            rsp.byte_class = btlv_pkg::CLASS_LENGTH;
            rsp.tlv_tag    = tag_ff;
            if ((eff_phase == btlv_pkg::PH_DESC && !desc_long) ||
                (eff_phase == btlv_pkg::PH_LENB && lenb_last)) begin
               if (hdr_bad) begin
                  rsp.error_code = btlv_pkg::ERR_VALUE_OVERRUN;
               end else begin
                  rsp.value_length = hdr_len;
                  rsp.value_offset = voff[15:0];
                  rsp.header_done  = 1'b1;
                  rsp.tlv_done     = (hdr_len == 16'd0);
               end
            end else if (eff_phase == btlv_pkg::PH_DESC) begin
               if (desc_bad_lol) begin
                  rsp.error_code = btlv_pkg::ERR_BAD_LEN_OF_LEN;
               end else if (desc_overrun) begin
                  rsp.error_code = btlv_pkg::ERR_LEN_OVERRUN;
               end
            end
         end
         btlv_pkg::PH_VALUE: begin
            rsp.byte_class = btlv_pkg::CLASS_VALUE;
            rsp.tlv_tag    = tag_ff;
            rsp.tlv_done   = val_last;
         end
         default: begin
            rsp.byte_class = btlv_pkg::CLASS_IGNORED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= btlv_pkg::PH_HALT;
         offset_ff   <= '0;
         buf_len_ff  <= '0;
         tag_ff      <= '0;
         len_left_ff <= '0;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         val_left_ff <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         offset_ff   <= offset_in;
         buf_len_ff  <= buf_len_in;
         tag_ff      <= tag_in;
         len_left_ff <= len_left_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         val_left_ff <= val_left_in;
      end
   end

   `BTLV_ASSERT_IMPL(a_value_left_nonzero, clock, reset, phase_ff == btlv_pkg::PH_VALUE, val_left_ff != 16'd0, "value phase entered with nothing left")
   `BTLV_ASSERT_IMPL(a_lenb_left_nonzero, clock, reset, phase_ff == btlv_pkg::PH_LENB, len_left_ff != '0, "length phase entered with no length bytes left")
   `BTLV_ASSERT_NEXT(a_halt_holds, clock, reset, step && !buffer_start && phase_ff == btlv_pkg::PH_HALT, phase_ff == btlv_pkg::PH_HALT && $stable(offset_ff), "halted parser moved without a buffer start")

endmodule

`default_nettype wire

>>> hw/rtl/ber_tlv_stream_parser.sv
// ============================================================================
// BER TLV stream parser - top level
// Splits a byte stream into one-byte-tag BER TLVs with bound checking.
// ============================================================================
//
// The req channel carries one buffer byte per transfer. The first byte of a
// buffer has req_buffer_start high and brings the buffer length, which is
// sampled only then. The rsp channel returns exactly one result per byte:
// its class, the TLV tag, header results when a tag/length header completes,
// the end-of-TLV flag and an error code.
// A byte is first captured in the input register, then its result is
// loaded into the output register, which drives rsp_valid. One byte is
// taken every cycle while the receiver keeps up; the rate is set by the
// combinational parse step between the two registers. When rsp_ready is
// low the output register holds its result, the input register holds one
// more byte, and req_ready then drops until the output drains.
// After reset the parser is halted and both registers are empty; bytes are
// reported as ignored until a transfer with req_buffer_start arrives. After
// an error it halts again in the same way.
//
`default_nettype none

`include "ber_tlv_stream_parser_defines.svh"

module ber_tlv_stream_parser #(
   parameter int LEN_BYTES_MAX = btlv_pkg::LEN_BYTES_MAX_DEF,
   parameter int OFFSET_BITS   = btlv_pkg::OFFSET_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_buffer_start,
   input  wire logic [15:0] req_buffer_length,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [1:0]  rsp_byte_class,
   output      logic [7:0]  rsp_tlv_tag,
   output      logic [15:0] rsp_value_length,
   output      logic [15:0] rsp_value_offset,
   output      logic        rsp_header_done,
   output      logic        rsp_tlv_done,
   output      logic [2:0]  rsp_error_code
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_data_ff;
   logic              in_start_ff;
   logic [15:0]       in_len_ff;
   logic              out_valid_ff, out_valid_in;
   btlv_pkg::rsp_type out_ff;
   btlv_pkg::rsp_type core_rsp;
   logic              advance;
   logic              req_xfer;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   btlv_core #(
      .LEN_BYTES_MAX (LEN_BYTES_MAX),
      .OFFSET_BITS   (OFFSET_BITS)
   ) u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .data_byte     (in_data_ff),
      .buffer_start  (in_start_ff),
      .buffer_length (in_len_ff),
      .rsp           (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff  <= req_data_byte;
         in_start_ff <= req_buffer_start;
         in_len_ff   <= req_buffer_length;
      end
      if (advance) begin
         out_ff <= core_rsp;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_class   = out_ff.byte_class;
   assign rsp_tlv_tag      = out_ff.tlv_tag;
   assign rsp_value_length = out_ff.value_length;
   assign rsp_value_offset = out_ff.value_offset;
   assign rsp_header_done  = out_ff.header_done;
   assign rsp_tlv_done     = out_ff.tlv_done;
   assign rsp_error_code   = out_ff.error_code;

   `BTLV_ASSERT_IMPL(a_header_is_length_byte, clock, reset, out_valid_ff && out_ff.header_done, out_ff.byte_class == btlv_pkg::CLASS_LENGTH && out_ff.error_code == btlv_pkg::ERR_NONE, "header completed on a non-length byte or with an error")
   `BTLV_ASSERT_IMPL(a_error_no_done, clock, reset, out_valid_ff && out_ff.error_code != btlv_pkg::ERR_NONE, !out_ff.header_done && !out_ff.tlv_done, "error result also flags completion")
   `BTLV_ASSERT_NEXT(a_stalled_byte_kept, clock, reset, in_valid_ff && !advance, in_valid_ff, "stalled input byte was dropped")

endmodule

`default_nettype wire
